// File: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared types and constants of the sha-256 hash engine
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned DigestWords = 8;
	localparam int unsigned BlockBytes  = 64;
	localparam int unsigned LengthPos   = 56;
	localparam logic [7:0]  PadByte     = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef logic [7:0][31:0] hash_t;

	localparam hash_t StartHash = {
		32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
		32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
	};

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'h428A2F98; 6'd1: k = 32'h71374491;
			6'd2: k = 32'hB5C0FBCF; 6'd3: k = 32'hE9B5DBA5;
			6'd4: k = 32'h3956C25B; 6'd5: k = 32'h59F111F1;
			6'd6: k = 32'h923F82A4; 6'd7: k = 32'hAB1C5ED5;
			6'd8: k = 32'hD807AA98; 6'd9: k = 32'h12835B01;
			6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
			6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
			6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
			6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
			6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
			6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
			6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
			6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
			6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
			6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
			6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
			6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
			6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
			6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
			6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
			6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
			6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
			6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
			6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
			6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
			6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
			6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
			6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
			6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
			6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
			6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_ROUND = 6'b000100,
		ST_ADD   = 6'b001000,
		ST_PAD   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	// control from the sequencer to the round unit
	typedef struct packed {
		logic       start;
		logic       load;
		logic [3:0] load_idx;
		logic [31:0] load_word;
		logic       step;
		logic [5:0] round;
		logic       fold;
		logic       init;
	} round_ctl_t;

endpackage

// File: rtl/sha_if.sv
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// valid/ready channels of the hash engine
// ----------------------------------------------------------------------------
interface sha_in_if;
	logic              valid;
	logic              ready;
	sha_pkg::in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if;
	logic               valid;
	logic               ready;
	sha_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/sha_round.sv
// ----------------------------------------------------------------------------
// sha_round
// one sha-256 round per cycle while step is set, over a rolling 16-word schedule
// ----------------------------------------------------------------------------
module sha_round (
	input  logic                clk,
	input  logic                arst_n,
	input  sha_pkg::round_ctl_t ctl,
	output sha_pkg::hash_t      hash
);
	sha_pkg::hash_t hash_q;
	sha_pkg::hash_t work_q;
	logic [15:0][31:0] win_q;

	logic [31:0] x, y, w, t1, t2, e, a;
	logic [3:0]  r4;

	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	always_comb begin
		r4 = ctl.round[3:0];
		x  = win_q[r4 + 4'd1];
		y  = win_q[r4 + 4'd14];
		if (ctl.round < 6'd16) begin
			w = win_q[r4];
		end else begin
			w = win_q[r4] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + win_q[r4 + 4'd9]
				+ (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
		end
		e  = work_q[4];
		a  = work_q[0];
		t1 = work_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
			+ ((e & work_q[5]) ^ (~e & work_q[6])) + sha_pkg::round_k(ctl.round) + w;
		t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
			+ ((a & work_q[1]) ^ (a & work_q[2]) ^ (work_q[1] & work_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= sha_pkg::StartHash;
		end else if (ctl.init) begin
			hash_q <= sha_pkg::StartHash;
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + work_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) win_q[ctl.load_idx] <= ctl.load_word;
		if (ctl.start) work_q <= hash_q;
		if (ctl.step) begin
			win_q[r4] <= w;
			for (int i = 1; i < 8; i++) work_q[i] <= work_q[i-1];
			work_q[4] <= work_q[3] + t1;
			work_q[0] <= t1 + t2;
		end
	end

	assign hash = hash_q;
endmodule

// File: rtl/sha256_hash_engine_core.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_core
// sha-256 over a byte stream with padding and digest output
// ----------------------------------------------------------------------------
// channel   dir   payload                               transaction
// in_ch     in    data_byte, has_byte, last             one byte and/or end mark
// out_ch    out   digest_word, word_index, last_word    one digest word
//
// a byte transaction is accepted in idle; one that fills the block starts its load
// a full block is loaded through the byte-wide registered block memory reads,
// then takes 64 rounds in the single round unit and one fold
// a last transaction adds a pad pass plus a block for each of the one or
// two padded blocks, then eight output words
// out_ch stalls simply hold the sequencer in the output state
// reset restores the initial hash; the block memory needs no clearing
module sha256_hash_engine_core (
	input logic     clk,
	input logic     arst_n,
	sha_in_if.sink  in_ch,
	sha_out_if.source out_ch
);
	sha_pkg::state_t    state_q;
	logic [5:0]         fill_q;       // bytes held in the block
	logic [63:0]        bits_q;       // message length in bits
	logic [7:0]         mem [64];
	logic [5:0]         cnt_q;        // load byte / round / pad position
	logic [31:0]        word_q;       // word gathered from block memory
	logic               final_q;      // current block is the last padded one
	logic               ending_q;     // message end pending after this block
	logic               extra_q;      // length spills into a second block
	logic [2:0]         oidx_q;
	sha_pkg::round_ctl_t ctl;
	sha_pkg::hash_t     hash;

	logic       acc;
	logic [7:0] rd_q;
	logic       wr_en;
	logic [5:0] wr_addr;
	logic [7:0] wr_data;

	assign in_ch.ready = (state_q == sha_pkg::ST_IDLE);
	assign acc = in_ch.valid && in_ch.ready;

	// block memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[cnt_q];
	end

	// pad byte at a position of the padded block
	function automatic logic [7:0] pad_byte(input logic [5:0] p, input logic [5:0] fill,
		input logic [63:0] bits, input logic fin);
		logic [7:0] b;
		b = 8'h00;
		if (p == fill && !fin) b = sha_pkg::PadByte;
		if (p >= 6'(sha_pkg::LengthPos) && fin) b = bits[8*(63-p) +: 8];
		return b;
	endfunction

	// write port: incoming bytes when idle, padding in the pad state
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q;
		wr_data = in_ch.payload.data_byte;
		if (acc && in_ch.payload.has_byte) wr_en = 1'b1;
		if (state_q == sha_pkg::ST_PAD && cnt_q >= fill_q) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q;
			wr_data = pad_byte(cnt_q, fill_q, bits_q, final_q);
			if (cnt_q == fill_q && final_q && !extra_q) wr_data = sha_pkg::PadByte;
			if (cnt_q == fill_q && extra_q && final_q) wr_data = 8'h00;
		end
	end

	// sequencer and round unit control
	logic [6:0] lcnt_q;   // load step counter, 65 steps with read latency
	always_comb begin
		ctl = '0;
		ctl.round     = cnt_q;
		ctl.load_idx  = lcnt_q[5:2] - 4'd1;
		ctl.load_word = {word_q[23:0], rd_q};
		ctl.load      = (state_q == sha_pkg::ST_LOAD) && lcnt_q != 7'd0
			&& lcnt_q[1:0] == 2'd0;
		ctl.start     = (state_q == sha_pkg::ST_LOAD) && lcnt_q == 7'd64;
		ctl.step      = (state_q == sha_pkg::ST_ROUND);
		ctl.fold      = (state_q == sha_pkg::ST_ADD);
		ctl.init      = (state_q == sha_pkg::ST_OUT) && out_ch.ready && oidx_q == 3'd7;
	end

	always_ff @(posedge clk) begin
		if (state_q == sha_pkg::ST_LOAD) word_q <= {word_q[23:0], rd_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha_pkg::ST_IDLE;
			fill_q   <= '0;
			bits_q   <= '0;
			cnt_q    <= '0;
			lcnt_q   <= '0;
			final_q  <= 1'b0;
			ending_q <= 1'b0;
			extra_q  <= 1'b0;
			oidx_q   <= '0;
		end else begin
			case (state_q)
				sha_pkg::ST_IDLE: begin
					if (acc) begin
						logic [6:0] nf;
						nf = {1'b0, fill_q} + {6'd0, in_ch.payload.has_byte};
						if (in_ch.payload.has_byte) bits_q <= bits_q + 64'd8;
						ending_q <= in_ch.payload.last;
						cnt_q    <= '0;
						lcnt_q   <= '0;
						if (nf[6]) begin
							fill_q  <= '0;
							final_q <= 1'b0;
							state_q <= sha_pkg::ST_LOAD;
						end else begin
							fill_q <= nf[5:0];
							if (in_ch.payload.last) begin
								extra_q <= nf[5:0] >= 6'(sha_pkg::LengthPos);
								final_q <= nf[5:0] < 6'(sha_pkg::LengthPos);
								state_q <= sha_pkg::ST_PAD;
							end
						end
					end
				end
				sha_pkg::ST_PAD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						cnt_q   <= '0;
						lcnt_q  <= '0;
						state_q <= sha_pkg::ST_LOAD;
					end
				end
				sha_pkg::ST_LOAD: begin
					// data of read address cnt_q appears in rd_q in the next cycle
					cnt_q  <= cnt_q + 6'd1;
					lcnt_q <= lcnt_q + 7'd1;
					if (lcnt_q == 7'd64) begin
						cnt_q   <= '0;
						state_q <= sha_pkg::ST_ROUND;
					end
				end
				sha_pkg::ST_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= sha_pkg::ST_ADD;
				end
				sha_pkg::ST_ADD: begin
					cnt_q <= '0;
					if (final_q) begin
						oidx_q  <= '0;
						state_q <= sha_pkg::ST_OUT;
					end else if (ending_q) begin
						// padding after a full block or a spilled length
						// the whole block is rewritten from position 0
						final_q <= 1'b1;
						extra_q <= extra_q;
						fill_q  <= '0;
						state_q <= sha_pkg::ST_PAD;
					end else begin
						state_q <= sha_pkg::ST_IDLE;
					end
				end
				sha_pkg::ST_OUT: begin
					if (out_ch.ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							fill_q   <= '0;
							bits_q   <= '0;
							final_q  <= 1'b0;
							ending_q <= 1'b0;
							extra_q  <= 1'b0;
							state_q  <= sha_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= sha_pkg::ST_IDLE;
			endcase
		end
	end

	sha_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.hash   (hash)
	);

	assign out_ch.valid               = (state_q == sha_pkg::ST_OUT);
	assign out_ch.payload.digest_word = hash[oidx_q];
	assign out_ch.payload.word_index  = oidx_q;
	assign out_ch.payload.last_word   = (oidx_q == 3'd7);

	// no new transaction while a block is in work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sha_pkg::ST_IDLE) |-> !in_ch.ready)
		else $error("input taken while busy");
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_ROUND && cnt_q == 6'd63) |=> (state_q == sha_pkg::ST_ADD))
		else $error("round count lost");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(oidx_q)))
		else $error("digest word dropped");
endmodule
